[hdl/lpfs_pkg.sv]
// ----------------------------------------------------------------------------
// lpfs_pkg: shared types and constants of the potential-field steering block
// Holds the fixed-point constants, the quarter-wave sine table and the
// request and status words that pass between the sequencer and the divider.
// ----------------------------------------------------------------------------
package lpfs_pkg;

  // Field widths fixed by the interface.
  localparam int ANGLE_W  = 16;
  localparam int RANGE_W  = 16;
  localparam int TRIG_W   = 16;
  localparam int WEIGHT_W = 15;
  localparam int SUM_W    = 27;
  localparam int SPEED_W  = 14;
  localparam int TURN_W   = 16;

  // Divider datapath widths.
  localparam int DIV_REM_W  = 33;
  localparam int DIV_NUM_W  = 32;
  localparam int DIV_STEP_W = 5;

  // Iteration counts: the weight quotient never exceeds 2^14, averages fit 27 bits.
  localparam logic [DIV_STEP_W-1:0] WEIGHT_STEPS = 5'd15;
  localparam logic [DIV_STEP_W-1:0] AVG_STEPS    = 5'd27;

  // Fixed-point constants in Q1.14.
  localparam int BASE_SPEED = 4915;
  localparam int ONE_Q14    = 16384;
  localparam int SPEED_MAX  = 9830;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_ANGLE = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 16'd49152;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 16'd64;

  // Quarter-wave sine table, Q1.14, 256 angle units per entry.
  localparam logic [14:0] QUARTER_SINE [65] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,
    15'd2801,  15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,
    15'd5520,  15'd5897,  15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,
    15'd8076,  15'd8423,  15'd8765,  15'd9102,  15'd9434,  15'd9760,  15'd10080,
    15'd10394, 15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
    15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623, 15'd13842,
    15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978, 15'd15137,
    15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364,
    15'd16379, 15'd16384
  };

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_REM_W-1:0]  den;
  } div_req_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/lpfs_div.sv]
// ----------------------------------------------------------------------------
// lpfs_div: shared restoring divider
// Produces one quotient bit per cycle. The caller supplies the starting
// partial remainder and the remaining dividend bits left aligned, so one
// unit serves both the weight division and the scan averages.
// ----------------------------------------------------------------------------
module lpfs_div
  import lpfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output div_stat_t            stat,
  output logic [DIV_NUM_W-1:0] quot
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_REM_W-1:0]  rem_r, rem_nxt;
  logic [DIV_NUM_W-1:0]  num_r, num_nxt;
  logic [DIV_REM_W-1:0]  den_r, den_nxt;
  logic [DIV_REM_W+1:0]  trial;
  logic                  ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {1'b0, rem_r, num_r[DIV_NUM_W-1]} - {2'b00, den_r};
  assign ge    = ~trial[DIV_REM_W+1];

  // Next-state logic: load on start, then one step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      num_nxt  = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[DIV_REM_W-1:0] : {rem_r[DIV_REM_W-2:0], num_r[DIV_NUM_W-1]};
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = num_r;

endmodule

[hdl/lpfs_trig.sv]
// ----------------------------------------------------------------------------
// lpfs_trig: table sine with linear interpolation
// Maps a binary-turn angle to a Q1.14 sine using the quarter-wave table and
// quadrant symmetry. The sequencer registers its result.
// ----------------------------------------------------------------------------
module lpfs_trig
  import lpfs_pkg::*;
(
  input  logic        [ANGLE_W-1:0] angle,
  output logic signed [TRIG_W-1:0]  value
);

  logic [1:0]  quad;
  logic [14:0] pos;
  logic [6:0]  idx;
  logic [6:0]  lo_idx, hi_idx;
  logic [7:0]  frac;
  logic [14:0] lo, hi;
  logic [8:0]  diff;
  logic [16:0] prod;
  logic [17:0] rnd;
  logic [14:0] interp;
  logic [14:0] mag;
  logic        top;

  // Fold the angle into the first quadrant.
  always_comb begin
    quad   = angle[15:14];
    pos    = quad[0] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    idx    = pos[14:8];
    frac   = pos[7:0];
    top    = (idx >= 7'd64);
    lo_idx = top ? 7'd64 : idx;
    hi_idx = top ? 7'd64 : idx + 7'd1;
  end

  // Interpolate between neighboring table entries.
  always_comb begin
    lo     = QUARTER_SINE[lo_idx];
    hi     = QUARTER_SINE[hi_idx];
    diff   = 9'(hi - lo);
    prod   = diff * frac;
    rnd    = {1'b0, prod} + 18'd128;
    interp = lo + 15'(rnd >> 8);
    mag    = top ? 15'(ONE_Q14) : interp;
    value  = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

endmodule

[hdl/laser_potential_field_steering.sv]
// ----------------------------------------------------------------------------
// laser_potential_field_steering: potential-field steering from a laser scan
// Range words enter on the in_ channel, one per sample; in_last_sample marks
// the final word of a scan. Each sample adds a repulsion weighted by
// 1/(1+d^2) against the sample direction to two sums. After the last word the
// block emits one output word: forward speed and turn rate in Q1.14.
// The cfg_ port sets the start angle and the angle step between samples;
// write it only while the block is idle.
// An accumulated sample holds in_ready low from acceptance until it is added
// to both sums; the weight comes from 15 steps of the shared
// one-bit-per-cycle divider. A last sample adds two 27-step average
// divisions on the same divider, then the output word.
// Samples past MAX_SAMPLES in one scan are ignored; a last one still ends it.
// Reset clears the sums and count, loads the default angle registers and
// empties the output register. The output register holds a word until
// out_ready; a further result waits in the sequencer, and in_ready stays low
// until the waiting result has moved into the output register.
// ----------------------------------------------------------------------------
module laser_potential_field_steering
  import lpfs_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic        [RANGE_W-1:0] in_range_sample,
  input  logic                      in_last_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [SPEED_W-1:0] out_forward_speed,
  output logic signed [TURN_W-1:0]  out_turn_rate,
  input  logic                      cfg_we,
  input  logic        [1:0]         cfg_index,
  input  logic        [ANGLE_W-1:0] cfg_wdata
);

  localparam int              CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SQ   = 11'b000_0000_0010,
    S_WST  = 11'b000_0000_0100,
    S_WDIV = 11'b000_0000_1000,
    S_TC   = 11'b000_0001_0000,
    S_TS   = 11'b000_0010_0000,
    S_ACC  = 11'b000_0100_0000,
    S_DLIN = 11'b000_1000_0000,
    S_WLIN = 11'b001_0000_0000,
    S_DROT = 11'b010_0000_0000,
    S_WROT = 11'b100_0000_0000
  } state_t;

  // Emission is folded into S_WROT's successor via hold registers.
  state_t state_r, state_nxt;
  logic   emit_r, emit_nxt;

  logic        [ANGLE_W-1:0] start_r, start_nxt;
  logic        [ANGLE_W-1:0] step_r, step_nxt;
  logic        [ANGLE_W-1:0] ang_r, ang_nxt;
  logic signed [SUM_W-1:0]   lin_r, lin_nxt;
  logic signed [SUM_W-1:0]   rot_r, rot_nxt;
  logic        [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic        [RANGE_W-1:0]  rng_r, rng_nxt;
  logic                       last_r, last_nxt;
  logic        [31:0]         sq_r, sq_nxt;
  logic signed [TRIG_W-1:0]   cos_r, cos_nxt;
  logic signed [TRIG_W-1:0]   sin_r, sin_nxt;
  logic        [WEIGHT_W-1:0] w_r, w_nxt;
  logic signed [TRIG_W-1:0]   term_r, term_nxt;
  logic        [SPEED_W-1:0]  fwd_hold_r, fwd_hold_nxt;
  logic signed [TURN_W-1:0]   turn_hold_r, turn_hold_nxt;
  logic        [SPEED_W-1:0]  fwd_r, fwd_nxt;
  logic signed [TURN_W-1:0]   turn_r, turn_nxt;

  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic     [DIV_NUM_W-1:0] div_quot;

  logic        [ANGLE_W-1:0]  trig_ang;
  logic signed [TRIG_W-1:0]   trig_val;
  logic        [DIV_REM_W-1:0] w_den;
  logic        [DIV_NUM_W-1:0] w_num;
  logic signed [TRIG_W-1:0]   term_src;
  logic        [14:0]         term_mag;
  logic        [29:0]         term_prod;
  logic        [15:0]         term_abs;
  logic signed [TRIG_W-1:0]   term_val;
  logic        [SUM_W-1:0]    avg_mag;
  logic        [DIV_REM_W-1:0] avg_den;
  logic        [SUM_W-1:0]    avg_q;
  logic        [12:0]         lin_clamp;
  logic        [14:0]         rot_clamp;

  // Saturating add of a repulsion term to a 27-bit sum.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] s,
    input logic signed [TRIG_W-1:0] t
  );
    logic signed [SUM_W:0] x;
    x = {s[SUM_W-1], s} + {{(SUM_W+1-TRIG_W){t[TRIG_W-1]}}, t};
    if (x[SUM_W] != x[SUM_W-1]) begin
      sat_add = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = x[SUM_W-1:0];
    end
  endfunction

  lpfs_trig u_trig (
    .angle (trig_ang),
    .value (trig_val)
  );

  lpfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Cosine is the sine a quarter turn ahead.
  assign trig_ang = (state_r == S_WST) ? ang_r + 16'd16384 : ang_r;

  // Weight division operands: round(2^30 / (2^16 + r^2)).
  always_comb begin
    w_den = 33'd65536 + {1'b0, sq_r};
    w_num = 32'h4000_0000 + w_den[DIV_REM_W-1:1];
  end

  // Repulsion term: magnitude times weight, rounded, opposite sign.
  always_comb begin
    term_src  = (state_r == S_TC) ? cos_r : sin_r;
    term_mag  = term_src[TRIG_W-1] ? 15'(-term_src) : term_src[14:0];
    term_prod = term_mag * w_r;
    term_abs  = 16'((term_prod + 30'd8192) >> 14);
    term_val  = term_src[TRIG_W-1] ? $signed(term_abs) : -$signed(term_abs);
  end

  // Average division operands and output clamps.
  always_comb begin
    if (state_r == S_DLIN) begin
      avg_mag = lin_r[SUM_W-1] ? 27'(-lin_r) : 27'(lin_r);
    end else begin
      avg_mag = rot_r[SUM_W-1] ? 27'(-rot_r) : 27'(rot_r);
    end
    avg_den   = (cnt_r == '0) ? 33'd1 : 33'(cnt_r);
    avg_q     = div_quot[SUM_W-1:0];
    lin_clamp = (avg_q > 27'(BASE_SPEED)) ? 13'(BASE_SPEED) : avg_q[12:0];
    rot_clamp = (avg_q > 27'(ONE_Q14)) ? 15'(ONE_Q14) : avg_q[14:0];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    emit_nxt      = emit_r;
    start_nxt     = start_r;
    step_nxt      = step_r;
    ang_nxt       = ang_r;
    lin_nxt       = lin_r;
    rot_nxt       = rot_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    rng_nxt       = rng_r;
    last_nxt      = last_r;
    sq_nxt        = sq_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    w_nxt         = w_r;
    term_nxt      = term_r;
    fwd_hold_nxt  = fwd_hold_r;
    turn_hold_nxt = turn_hold_r;
    fwd_nxt       = fwd_r;
    turn_nxt      = turn_r;
    div_req       = '0;

    // The output word leaves when the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (emit_r) begin
          // A finished result waits for the output register to free up.
          if (!out_valid_r || out_ready) begin
            out_valid_nxt = 1'b1;
            fwd_nxt       = fwd_hold_r;
            turn_nxt      = turn_hold_r;
            emit_nxt      = 1'b0;
            lin_nxt       = '0;
            rot_nxt       = '0;
            cnt_nxt       = '0;
            ang_nxt       = start_r;
          end
        end else if (in_valid) begin
          rng_nxt  = in_range_sample;
          last_nxt = in_last_sample;
          if (cnt_r < CNT_MAX) begin
            state_nxt = S_SQ;
          end else if (in_last_sample) begin
            state_nxt = S_DLIN;
          end
        end
      end
      S_SQ: begin
        sq_nxt    = rng_r * rng_r;
        state_nxt = S_WST;
      end
      S_WST: begin
        div_req.start    = 1'b1;
        div_req.steps    = WEIGHT_STEPS;
        div_req.rem_init = 33'(w_num[DIV_NUM_W-1:15]);
        div_req.num      = {w_num[14:0], 17'd0};
        div_req.den      = w_den;
        cos_nxt          = trig_val;
        state_nxt        = S_WDIV;
      end
      S_WDIV: begin
        sin_nxt = trig_val;
        if (div_stat.done) begin
          w_nxt     = div_quot[WEIGHT_W-1:0];
          state_nxt = S_TC;
        end
      end
      S_TC: begin
        term_nxt  = term_val;
        state_nxt = S_TS;
      end
      S_TS: begin
        lin_nxt   = sat_add(lin_r, term_r);
        term_nxt  = term_val;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rot_nxt   = sat_add(rot_r, term_r);
        cnt_nxt   = cnt_r + CNT_W'(1);
        ang_nxt   = ang_r + step_r;
        state_nxt = last_r ? S_DLIN : S_IDLE;
      end
      S_DLIN: begin
        div_req.start    = 1'b1;
        div_req.steps    = AVG_STEPS;
        div_req.rem_init = '0;
        div_req.num      = {avg_mag, 5'd0};
        div_req.den      = avg_den;
        state_nxt        = S_WLIN;
      end
      S_WLIN: begin
        if (div_stat.done) begin
          fwd_hold_nxt = lin_r[SUM_W-1] ? 14'(BASE_SPEED) - {1'b0, lin_clamp}
                                        : 14'(BASE_SPEED) + {1'b0, lin_clamp};
          state_nxt    = S_DROT;
        end
      end
      S_DROT: begin
        div_req.start    = 1'b1;
        div_req.steps    = AVG_STEPS;
        div_req.rem_init = '0;
        div_req.num      = {avg_mag, 5'd0};
        div_req.den      = avg_den;
        state_nxt        = S_WROT;
      end
      S_WROT: begin
        if (div_stat.done) begin
          turn_hold_nxt = rot_r[SUM_W-1] ? -$signed({1'b0, rot_clamp})
                                         : $signed({1'b0, rot_clamp});
          emit_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes must arrive only while the block is idle; the block does not enforce it.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_ANGLE: begin
          start_nxt = cfg_wdata;
          if (cnt_r == '0) begin
            ang_nxt = cfg_wdata;
          end
        end
        REG_ANGLE_STEP: begin
          step_nxt = cfg_wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_r      <= 1'b0;
      start_r     <= START_ANGLE_RST;
      step_r      <= ANGLE_STEP_RST;
      ang_r       <= START_ANGLE_RST;
      lin_r       <= '0;
      rot_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_r      <= emit_nxt;
      start_r     <= start_nxt;
      step_r      <= step_nxt;
      ang_r       <= ang_nxt;
      lin_r       <= lin_nxt;
      rot_r       <= rot_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rng_r       <= rng_nxt;
    last_r      <= last_nxt;
    sq_r        <= sq_nxt;
    cos_r       <= cos_nxt;
    sin_r       <= sin_nxt;
    w_r         <= w_nxt;
    term_r      <= term_nxt;
    fwd_hold_r  <= fwd_hold_nxt;
    turn_hold_r <= turn_hold_nxt;
    fwd_r       <= fwd_nxt;
    turn_r      <= turn_nxt;
  end

  assign in_ready          = (state_r == S_IDLE) && !emit_r;
  assign out_valid         = out_valid_r;
  assign out_forward_speed = fwd_r;
  assign out_turn_rate     = turn_r;

  // The sample count never passes the configured limit.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("sample count above limit");

  // A shown forward speed stays within base speed plus the clamp.
  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fwd_r <= 14'(SPEED_MAX)))
    else $error("forward speed out of range");

  // A shown turn rate stays within one unit either way.
  a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((turn_r >= -16'sd16384) && (turn_r <= 16'sd16384)))
    else $error("turn rate out of range");

  // The divider is never left running while a new word can be taken.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_stat.busy)
    else $error("divider busy while ready");

endmodule

[tb/laser_potential_field_steering_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_potential_field_steering_tb: self-checking bench for the steering block
// Feeds laser scans through the in_ channel, computes the expected speed and
// turn rate of every finished scan in a bit-exact fixed-point predictor and
// compares each output word with it. Angle registers are rewritten between
// phases, also in the middle of a scan, and both channels idle and stall.
// ----------------------------------------------------------------------------
module laser_potential_field_steering_tb
  import lpfs_pkg::*;
();

  // Bench constants.
  localparam int SCAN_LIMIT     = 1024;
  localparam int SPEED_BIAS     = 4915;
  localparam int UNIT_Q14       = 16384;
  localparam longint ACC_HI     = 64'sd67108863;
  localparam longint ACC_LO     = -64'sd67108864;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 2500;
  localparam int CYCLE_LIMIT    = 900000;
  localparam int PHASE_WORDS    = 100;

  // Register indexes that decode to nothing.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // Quarter-wave sine, Q1.14, one entry per 256 angle units.
  localparam int SINE_LUT [65] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590,
    3981, 4370, 4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366,
    7723, 8076, 8423, 8765, 9102, 9434, 9760, 10080, 10394, 10702,
    11003, 11297, 11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
    13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978, 15137, 15286,
    15426, 15557, 15679, 15791, 15893, 15986, 16069, 16143, 16207, 16261,
    16305, 16340, 16364, 16379, 16384
  };

  typedef struct {
    logic [RANGE_W-1:0] rng_code;
    logic               last;
  } range_word_t;

  typedef struct {
    logic        [SPEED_W-1:0] speed;
    logic signed [TURN_W-1:0]  turn;
  } steer_cmd_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN} rx_style_t;

  // DUT connections, known from time zero.
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic        [RANGE_W-1:0] in_range_sample = '0;
  logic                      in_last_sample = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic        [SPEED_W-1:0] out_forward_speed;
  logic signed [TURN_W-1:0]  out_turn_rate;
  logic                      cfg_we = 1'b0;
  logic        [1:0]         cfg_index = '0;
  logic        [ANGLE_W-1:0] cfg_wdata = '0;

  // Pending scan words and expected output words.
  range_word_t scan_words_q[$];
  steer_cmd_t  steer_cmd_q[$];

  // Predictor state.
  logic [ANGLE_W-1:0] pr_start;
  logic [ANGLE_W-1:0] pr_step;
  logic [ANGLE_W-1:0] pr_angle;
  longint             pr_lin_sum;
  longint             pr_rot_sum;
  int                 pr_count;

  // Traffic shaping and bookkeeping.
  bit        tx_steady = 1'b1;
  int        burst_left = 0;
  int        gap_left = 0;
  rx_style_t rx_style = RX_ALWAYS;
  int        rx_phase = 0;
  int        hold_left = 0;
  int        holds_asked = 0;
  int        holds_served = 0;
  int        cycle_cnt = 0;
  int        mismatches = 0;
  int        samples_taken = 0;
  int        words_checked = 0;
  int        cfg_writes = 0;

  laser_potential_field_steering #(
    .MAX_SAMPLES(SCAN_LIMIT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_range_sample  (in_range_sample),
    .in_last_sample   (in_last_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_forward_speed(out_forward_speed),
    .out_turn_rate    (out_turn_rate),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Interpolated sine over the first quarter; p runs 0..16384.
  function automatic int quarter_wave(input logic [14:0] p);
    int idx;
    int fr;
    int acc;
    idx = int'(p[14:8]);
    fr  = int'(p[7:0]);
    if (idx >= 64) return UNIT_Q14;
    acc = (SINE_LUT[idx+1] - SINE_LUT[idx]) * fr + 128;
    return SINE_LUT[idx] + (acc >>> 8);
  endfunction

  // Full-circle sine by quadrant symmetry.
  function automatic int wave_sine(input logic [ANGLE_W-1:0] a);
    logic [14:0] p;
    int          v;
    p = {1'b0, a[13:0]};
    v = a[14] ? quarter_wave(15'd16384 - p) : quarter_wave(p);
    return a[15] ? -v : v;
  endfunction

  // Weight 1/(1+d^2) in Q1.14, rounded half up.
  function automatic longint range_weight(input logic [RANGE_W-1:0] r);
    longint den;
    den = 64'sd65536 + longint'(r) * longint'(r);
    return (64'sd1073741824 + den / 2) / den;
  endfunction

  // Repulsion against the trig direction, rounded half away from zero.
  function automatic longint repel_term(input int trig, input longint w);
    longint mag;
    longint t;
    mag = (trig < 0) ? -trig : trig;
    t = (mag * w + 8192) >>> 14;
    return (trig < 0) ? t : -t;
  endfunction

  function automatic longint clamp_sum(input longint v);
    if (v > ACC_HI) return ACC_HI;
    if (v < ACC_LO) return ACC_LO;
    return v;
  endfunction

  // Advance the predictor by one accepted word; a last word yields a command.
  task automatic accumulate_repulsion(input logic [RANGE_W-1:0] r, input logic last);
    longint     w;
    longint     lin;
    longint     rot;
    longint     div;
    steer_cmd_t cmd;
    if (pr_count < SCAN_LIMIT) begin
      w = range_weight(r);
      pr_lin_sum = clamp_sum(pr_lin_sum + repel_term(wave_sine(pr_angle + 16'd16384), w));
      pr_rot_sum = clamp_sum(pr_rot_sum + repel_term(wave_sine(pr_angle), w));
      pr_count++;
      pr_angle = pr_angle + pr_step;
    end
    if (last) begin
      div = (pr_count == 0) ? 1 : pr_count;
      lin = pr_lin_sum / div;
      rot = pr_rot_sum / div;
      if (lin > SPEED_BIAS) lin = SPEED_BIAS;
      else if (lin < -SPEED_BIAS) lin = -SPEED_BIAS;
      if (rot > UNIT_Q14) rot = UNIT_Q14;
      else if (rot < -UNIT_Q14) rot = -UNIT_Q14;
      cmd.speed = SPEED_W'(SPEED_BIAS + lin);
      cmd.turn  = TURN_W'(rot);
      steer_cmd_q.push_back(cmd);
      pr_lin_sum = 0;
      pr_rot_sum = 0;
      pr_count   = 0;
      pr_angle   = pr_start;
    end
  endtask

  // Sender: bursts of words with random gaps, or a steady stream.
  always @(posedge clk) begin
    range_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        accumulate_repulsion(in_range_sample, in_last_sample);
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (scan_words_q.size() > 0) begin
          nxt = scan_words_q.pop_front();
          in_valid        <= 1'b1;
          in_range_sample <= nxt.rng_code;
          in_last_sample  <= nxt.last;
          if (!tx_steady) begin
            if (burst_left == 0) begin
              burst_left = $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            end else begin
              burst_left--;
            end
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a long hold when asked, otherwise the current stall style.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= ((rx_phase % 23) < 13);
      endcase
    end
    rx_phase++;
  end

  // Checker: every output word against the oldest expected command.
  always @(posedge clk) begin
    steer_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (steer_cmd_q.size() == 0) begin
        $display("%0t: output word with none expected: speed %0d turn %0d",
                 $time, out_forward_speed, out_turn_rate);
        mismatches++;
      end else begin
        want = steer_cmd_q.pop_front();
        if (out_forward_speed !== want.speed) begin
          $display("%0t: forward_speed expected %0d, actual %0d",
                   $time, want.speed, out_forward_speed);
          mismatches++;
        end
        if (out_turn_rate !== want.turn) begin
          $display("%0t: turn_rate expected %0d, actual %0d",
                   $time, want.turn, out_turn_rate);
          mismatches++;
        end
        words_checked++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still expected", $time, steer_cmd_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void push_word(input logic [RANGE_W-1:0] d, input logic last);
    range_word_t w;
    w.rng_code = d;
    w.last     = last;
    scan_words_q.push_back(w);
  endfunction

  // Distances lean toward the near field where the weight matters.
  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return RANGE_W'($urandom_range(0, 1023));
      5, 6:    return RANGE_W'($urandom_range(0, 4095));
      default: return RANGE_W'($urandom);
    endcase
  endfunction

  // Queue one scan of random distances; the last word may be withheld.
  function automatic void push_scan(input int len, input bit closed);
    for (int k = 0; k < len; k++) begin
      push_word(pick_range(), closed && (k == len - 1));
    end
  endfunction

  // Register write while the block is idle; the predictor follows.
  task automatic set_reg(input logic [1:0] idx, input logic [ANGLE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_START_ANGLE: begin
        pr_start = val;
        if (pr_count == 0) pr_angle = val;
      end
      REG_ANGLE_STEP: pr_step = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait until every word is taken and every command seen, then let the
  // divider finish any sample still in flight.
  task automatic wait_quiet();
    @(negedge clk);
    while (scan_words_q.size() != 0 || in_valid || steer_cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Main sequence.
  initial begin
    int phase_words;
    int len;

    pr_start   = 16'd49152;
    pr_step    = 16'd64;
    pr_angle   = 16'd49152;
    pr_lin_sum = 0;
    pr_rot_sum = 0;
    pr_count   = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default angles, nearest and farthest ranges.
    push_word(16'd0, 1'b1);
    push_word(16'hFFFF, 1'b1);
    push_word(16'd0, 1'b0);
    push_word(16'd256, 1'b0);
    push_word(16'hFFFF, 1'b0);
    push_word(16'd1, 1'b1);
    wait_quiet();

    // Four quadrants cancel out.
    set_reg(REG_START_ANGLE, 16'd0);
    set_reg(REG_ANGLE_STEP, 16'd16384);
    repeat (3) push_word(16'd0, 1'b0);
    push_word(16'd0, 1'b1);
    // Obstacle dead ahead drives the speed to zero.
    push_word(16'd0, 1'b1);
    wait_quiet();

    // Obstacle behind pushes the speed to its maximum.
    set_reg(REG_START_ANGLE, 16'd32768);
    push_word(16'd0, 1'b1);
    wait_quiet();

    // Obstacle to the left, largest step.
    set_reg(REG_START_ANGLE, 16'd16384);
    set_reg(REG_ANGLE_STEP, 16'hFFFF);
    push_word(16'd0, 1'b0);
    push_word(16'd0, 1'b1);
    wait_quiet();

    // Top angle with a zero step; spare indexes change nothing.
    set_reg(REG_START_ANGLE, 16'hFFFF);
    set_reg(REG_ANGLE_STEP, 16'd0);
    push_word(16'd1, 1'b0);
    push_word(16'd128, 1'b0);
    push_word(16'd512, 1'b1);
    wait_quiet();
    set_reg(REG_SPARE_A, 16'h1234);
    set_reg(REG_SPARE_B, 16'hEDCB);
    push_word(16'd300, 1'b1);
    wait_quiet();

    // Rewrite in the middle of a scan: the start angle waits for the next scan.
    push_word(16'd10, 1'b0);
    push_word(16'd20, 1'b0);
    wait_quiet();
    set_reg(REG_START_ANGLE, 16'd8192);
    set_reg(REG_ANGLE_STEP, 16'd4096);
    push_word(16'd0, 1'b1);
    push_word(16'd0, 1'b1);
    wait_quiet();

    // Random phases with changing angles and traffic styles.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_reg(REG_START_ANGLE, 16'd0);
        1: set_reg(REG_START_ANGLE, 16'hFFFF);
        default: set_reg(REG_START_ANGLE, 16'($urandom));
      endcase
      case (ph)
        0: set_reg(REG_ANGLE_STEP, 16'hFFFF);
        1: set_reg(REG_ANGLE_STEP, 16'd1);
        2: set_reg(REG_ANGLE_STEP, 16'd0);
        default: set_reg(REG_ANGLE_STEP, 16'($urandom));
      endcase
      if (ph == 4) set_reg(REG_SPARE_B, 16'($urandom));
      rx_style  = rx_style_t'(ph % 3);
      tx_steady = (ph == 2);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        push_scan(len, 1'b1);
        phase_words += len;
      end
      // Odd phases stop mid-scan so the next writes land on a busy scan.
      if (ph % 2 == 1) push_scan($urandom_range(1, 5), 1'b0);
      wait_quiet();
    end

    // Long receiver hold while short scans keep coming.
    rx_style  = RX_COIN;
    tx_steady = 1'b1;
    holds_asked++;
    for (int k = 0; k < 14; k++) push_scan($urandom_range(1, 2), 1'b1);
    wait_quiet();

    // One scan past the sample limit; the extra words are dropped.
    tx_steady = 1'b0;
    set_reg(REG_START_ANGLE, 16'($urandom));
    set_reg(REG_ANGLE_STEP, 16'($urandom_range(0, 255)));
    push_scan(SCAN_LIMIT + 6, 1'b1);
    wait_quiet();

    repeat (100) @(posedge clk);
    $display("Covered %0d samples, %0d register writes, extreme angles and a full scan.",
             samples_taken, cfg_writes);
    $display("Checked %0d output words, %0d mismatches, %0d left unmatched.",
             words_checked, mismatches, steer_cmd_q.size());
    if (mismatches == 0 && steer_cmd_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
